// File: hw/rtl/qassd_pkg.sv
// package: types, constants and the segment lookup function of the quadrature angle display
`default_nettype none

package qassd_pkg;

	localparam int NUM_DIGITS  = 5;
	localparam int SCAN_W      = (NUM_DIGITS > 2) ? $clog2(NUM_DIGITS) : 1;
	localparam int CNT_W       = SCAN_W;
	localparam int COUNT_W     = 15;
	localparam int SCALE_W     = 4;
	localparam int SCALED_W    = 18;
	localparam int MAG_W       = 17;
	localparam int EN_W        = 5;
	localparam int SEG_W       = 7;
	localparam int S_DATA_W    = 8;
	localparam int M_DATA_W    = 32;
	localparam int M_PAYLOAD_W = EN_W + SEG_W + SCALED_W;

	localparam int unsigned DIG_LIMIT   = 10 ** NUM_DIGITS - 1;
	localparam int          COUNT_LIMIT = 11111;
	localparam logic [SCALE_W-1:0] SCALE_MAX   = 4'd9;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd9;

	// x / 10 == (x * RECIP10) >> RECIP_SH, exact for x below 2**22
	localparam logic [19:0] RECIP10  = 20'd838861;
	localparam int          RECIP_SH = 23;

	localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;
	localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

	// bit places of the input item in s_tdata
	localparam int IN_ENC_A = 0;
	localparam int IN_ENC_B = 1;
	localparam int IN_INDEX = 2;
	localparam int IN_STEP  = 3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LATCH,
		S_CONV,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_mag;
		logic conv_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic wrap;
		logic out_free;
	} sts_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qassd_ctrl.sv
// controller: sequences accept, frame latch, digit extraction and result load
`default_nettype none

module qassd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire qassd_pkg::sts_t sts,
	output qassd_pkg::cmd_t      cmd
);
	import qassd_pkg::*;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] conv_cnt_q;
	logic             conv_last;

	assign conv_last = (conv_cnt_q == CNT_W'(NUM_DIGITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			conv_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_LATCH) begin
				conv_cnt_q <= '0;
			end else if (state_q == S_CONV) begin
				conv_cnt_q <= conv_cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = sts.out_free;
				if (s_tvalid && sts.out_free) begin
					cmd.accept = 1'b1;
					state_nx   = sts.wrap ? S_LATCH : S_EMIT;
				end
			end
			S_LATCH: begin
				cmd.load_mag = 1'b1;
				state_nx     = S_CONV;
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (conv_last) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/qassd_dp.sv
// datapath: quadrature counter, scaler, digit extraction and result register
`default_nettype none

module qassd_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [qassd_pkg::SCALE_W-1:0]  cfg_data,
	input  wire logic [qassd_pkg::S_DATA_W-1:0] s_tdata,
	input  wire qassd_pkg::cmd_t                cmd,
	output qassd_pkg::sts_t                     sts,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [qassd_pkg::M_DATA_W-1:0]      m_tdata
);
	import qassd_pkg::*;

	logic [SCALE_W-1:0]        scale_q;
	logic                      prev_a_q;
	logic                      prev_idx_q;
	logic signed [COUNT_W-1:0] count_q;
	logic [SCAN_W-1:0]         scan_q;
	logic                      neg_q;
	logic [3:0]                digits_q [NUM_DIGITS];
	logic [MAG_W-1:0]          mag_q;
	logic                      out_valid_q;
	logic [M_PAYLOAD_W-1:0]    out_data_q;

	logic                       in_a, in_b, in_idx, in_step;
	logic                       scan_last;
	logic [SCALE_W-1:0]         eff_scale;
	logic signed [SCALED_W-1:0] cnt_ext, scl_ext, scaled;
	logic [SCALED_W-1:0]        abs_val;
	logic [MAG_W-1:0]           mag_clamped;
	logic [MAG_W+19:0]          prod;
	logic [MAG_W-1:0]           quot, rem_full;
	logic [SCAN_W-1:0]          lead;
	logic [EN_W-1:0]            en;
	logic [SEG_W-1:0]           pattern;

	assign in_a      = s_tdata[IN_ENC_A];
	assign in_b      = s_tdata[IN_ENC_B];
	assign in_idx    = s_tdata[IN_INDEX];
	assign in_step   = s_tdata[IN_STEP];
	assign scan_last = (scan_q == SCAN_W'(NUM_DIGITS - 1));

	assign sts.wrap     = in_step && scan_last;
	assign sts.out_free = !out_valid_q || m_tready;

	// scale above nine acts as nine
	assign eff_scale = (scale_q > SCALE_MAX) ? SCALE_MAX : scale_q;
	assign cnt_ext   = {{(SCALED_W-COUNT_W){count_q[COUNT_W-1]}}, count_q};
	assign scl_ext   = {{(SCALED_W-SCALE_W){1'b0}}, eff_scale};
	assign scaled    = cnt_ext * scl_ext;

	assign abs_val     = scaled[SCALED_W-1] ? SCALED_W'(-scaled) : SCALED_W'(scaled);
	assign mag_clamped = (32'(abs_val) > DIG_LIMIT) ? MAG_W'(DIG_LIMIT) : abs_val[MAG_W-1:0];

	// one decimal digit per step: quotient by reciprocal, remainder by shift-add
	assign prod     = (MAG_W+20)'(mag_q) * (MAG_W+20)'(RECIP10);
	assign quot     = MAG_W'(prod >> RECIP_SH);
	assign rem_full = mag_q - ((quot << 3) + (quot << 1));

	// leftmost non-zero digit, last position when all are zero
	always_comb begin
		lead = SCAN_W'(NUM_DIGITS - 1);
		for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
			if (digits_q[p] != 4'd0) begin
				lead = SCAN_W'(p);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < EN_W; i++) begin
			en[i] = (int'(scan_q) == i);
		end
	end

	always_comb begin
		if (scan_q >= lead) begin
			pattern = seg_of(digits_q[scan_q]);
		end else if (neg_q && ((scan_q + SCAN_W'(1)) == lead)) begin
			pattern = SEG_MINUS;
		end else begin
			pattern = SEG_BLANK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_RESET;
			prev_a_q   <= 1'b0;
			prev_idx_q <= 1'b1;
			count_q    <= '0;
			scan_q     <= '0;
			neg_q      <= 1'b0;
			for (int p = 0; p < NUM_DIGITS; p++) begin
				digits_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_data;
			end
			if (cmd.accept) begin
				prev_a_q   <= in_a;
				prev_idx_q <= in_idx;
				// index falling edge wins over an a edge
				if (prev_idx_q && !in_idx) begin
					count_q <= '0;
				end else if (in_a != prev_a_q) begin
					if (in_a == in_b) begin
						if (count_q < COUNT_W'(COUNT_LIMIT)) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end else begin
						if (count_q > -COUNT_W'(COUNT_LIMIT)) begin
							count_q <= count_q - COUNT_W'(1);
						end
					end
				end
				if (in_step) begin
					scan_q <= scan_last ? '0 : scan_q + SCAN_W'(1);
				end
			end
			if (cmd.load_mag) begin
				neg_q <= scaled[SCALED_W-1];
			end
			if (cmd.conv_step) begin
				// units first, shifted rightwards to the last position
				digits_q[0] <= rem_full[3:0];
				for (int p = 1; p < NUM_DIGITS; p++) begin
					digits_q[p] <= digits_q[p-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_mag) begin
			mag_q <= mag_clamped;
		end else if (cmd.conv_step) begin
			mag_q <= quot;
		end
		if (cmd.emit) begin
			out_data_q <= {scaled, pattern, en};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W-M_PAYLOAD_W){1'b0}}, out_data_q};

endmodule

`default_nettype wire

// File: hw/rtl/quadrature_angle_seven_segment_display_unit.sv
// quadrature angle counter with multiplexed seven-segment display drive
// an accepted item passes through S_EMIT into the result register; when the scan wraps
// and a new frame is latched it passes through S_LATCH, then S_CONV at one decimal digit per cycle
// from the shared divide-by-ten step, then S_EMIT; one item in flight at a time
// throughput: the next item is taken only back in S_IDLE with the result slot free or draining
// reset: asynchronous, count and scan cleared, scale 9, display frame shows a single 0
`default_nettype none

module quadrature_angle_seven_segment_display_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [qassd_pkg::SCALE_W-1:0]  cfg_data,   // degrees_per_count
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// enc_a, enc_b, index_level, scan_step, zero pad
	input  wire logic [qassd_pkg::S_DATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// digit_enable[4:0], segment_pattern[11:5], scaled_value[29:12], zero pad
	output logic [qassd_pkg::M_DATA_W-1:0]      m_tdata
);
	import qassd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	qassd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qassd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// an item is only taken when the result slot is free or draining
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while result slot is held");

	// one item in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken before result load");

	// at most one digit position enabled
	a_digit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[EN_W-1:0]))
		else $error("more than one digit enabled");

	// each accepted item on the plain path gives a result registered out of S_EMIT
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ##1 (m_tvalid || !s_tready))
		else $error("result missing after item");

endmodule

`default_nettype wire

// File: verif/qassd_readout_checker.sv
`timescale 1ns / 100ps
// checker: predicts each display readout of the quadrature angle unit and compares it
module qassd_readout_checker
	import qassd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [SCALE_W-1:0]    cfg_data,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [M_DATA_W-1:0]   m_tdata,
	output int                         mismatches,
	output int                         outstanding,
	output int                         items_seen,
	output int                         readouts_seen
);

	typedef struct packed {
		logic [EN_W-1:0]            en;
		logic [SEG_W-1:0]           seg;
		logic signed [SCALED_W-1:0] val;
	} readout_t;

	// digit glyphs 9 down to 0, digit 0 in the lowest bits
	localparam logic [10*SEG_W-1:0] GLYPHS = {
		7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	logic [SCALE_W-1:0] scale;
	logic               last_a;
	logic               last_index;
	int                 angle_count;
	int unsigned        scan_pos;
	int                 frame_val;
	logic [3:0]         frame_digs [NUM_DIGITS];
	readout_t           readouts_due [$];

	function automatic int scaled_angle();
		int s;
		s = (scale > SCALE_MAX) ? int'(SCALE_MAX) : int'(scale);
		return angle_count * s;
	endfunction

	task automatic latch_frame();
		int unsigned mag;
		frame_val = scaled_angle();
		mag = (frame_val < 0) ? -frame_val : frame_val;
		if (mag > DIG_LIMIT)
			mag = DIG_LIMIT;
		for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
			frame_digs[p] = 4'(mag % 10);
			mag = mag / 10;
		end
	endtask

	function automatic logic [SEG_W-1:0] glyph_at(input int unsigned pos);
		int unsigned lead;
		lead = NUM_DIGITS - 1;
		// leftmost non-zero digit, or the last position when the frame is zero
		for (int p = NUM_DIGITS - 1; p >= 0; p--)
			if (frame_digs[p] != 4'd0)
				lead = p;
		if (pos >= NUM_DIGITS)
			return SEG_BLANK;
		if (pos >= lead)
			return GLYPHS[frame_digs[pos]*SEG_W +: SEG_W];
		if (frame_val < 0 && pos + 1 == lead)
			return SEG_MINUS;
		return SEG_BLANK;
	endfunction

	task automatic predict_readout(input logic [S_DATA_W-1:0] d);
		logic     a, b, ix, st;
		readout_t r;
		a  = d[IN_ENC_A];
		b  = d[IN_ENC_B];
		ix = d[IN_INDEX];
		st = d[IN_STEP];
		if (a != last_a) begin
			if (a == b) begin
				if (angle_count < COUNT_LIMIT)
					angle_count++;
			end else if (angle_count > -COUNT_LIMIT) begin
				angle_count--;
			end
		end
		last_a = a;
		// index falling edge wins over an edge on a in the same item
		if (last_index && !ix)
			angle_count = 0;
		last_index = ix;
		if (st) begin
			if (scan_pos + 1 >= NUM_DIGITS) begin
				scan_pos = 0;
				latch_frame();
			end else begin
				scan_pos++;
			end
		end
		r.en  = EN_W'(1 << scan_pos);
		r.seg = glyph_at(scan_pos);
		r.val = SCALED_W'(scaled_angle());
		readouts_due.push_back(r);
	endtask

	task automatic flag_readout(input string why, input readout_t want, input readout_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s at readout %0d: en %b/%b seg %h/%h value %0d/%0d (expected/actual)",
				why, readouts_seen, want.en, got.en, want.seg, got.seg, want.val, got.val);
	endtask

	task automatic check_readout(input logic [M_DATA_W-1:0] d);
		readout_t got;
		readout_t want;
		got.en  = d[EN_W-1:0];
		got.seg = d[EN_W +: SEG_W];
		got.val = d[EN_W+SEG_W +: SCALED_W];
		readouts_seen++;
		if (readouts_due.size() == 0) begin
			flag_readout("readout with nothing pending", '0, got);
		end else begin
			want = readouts_due.pop_front();
			if (got.en !== want.en || got.seg !== want.seg || got.val !== want.val)
				flag_readout("readout mismatch", want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale       = SCALE_RESET;
			last_a      = 1'b0;
			last_index  = 1'b1;
			angle_count = 0;
			scan_pos    = 0;
			frame_val   = 0;
			for (int p = 0; p < NUM_DIGITS; p++)
				frame_digs[p] = 4'd0;
			readouts_due.delete();
			mismatches    = 0;
			outstanding   = 0;
			items_seen    = 0;
			readouts_seen = 0;
		end else begin
			if (cfg_we)
				scale = cfg_data;
			if (s_tvalid && s_tready) begin
				predict_readout(s_tdata);
				items_seen++;
			end
			if (m_tvalid && m_tready)
				check_readout(m_tdata);
			outstanding = readouts_due.size();
		end
	end

endmodule

// File: verif/tb_quadrature_angle_seven_segment_display_unit.sv
`timescale 1ns / 100ps
// testbench top: encoder stimulus, scale settings, idling phases and verdict
module tb_quadrature_angle_seven_segment_display_unit;

	import qassd_pkg::*;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                cfg_we   = 1'b0;
	logic [SCALE_W-1:0]  cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int   mismatches, outstanding, items_seen, readouts_seen;
	int   src_idle     = 0;
	int   sink_stall   = 0;
	int   scale_writes = 0;
	logic last_a       = 1'b0;
	logic last_b       = 1'b0;
	logic run_up       = 1'b1;
	int   run_left     = 0;
	int   index_low    = 0;

	quadrature_angle_seven_segment_display_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	qassd_readout_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.items_seen    (items_seen),
		.readouts_seen (readouts_seen)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= sink_stall);
		end
	end

	initial begin
		#5_000_000;
		$display("[quadrature_angle_seven_segment_display_unit] ERROR");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic push_sample(input logic a, input logic b, input logic ix, input logic st);
		logic [S_DATA_W-1:0] d;
		d = '0;
		d[IN_ENC_A] = a;
		d[IN_ENC_B] = b;
		d[IN_INDEX] = ix;
		d[IN_STEP]  = st;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		last_a = a;
		last_b = b;
	endtask

	// one quarter step of a proper quadrature walk
	task automatic quad_move(input logic up, input logic ix, input logic st);
		logic [1:0] ph;
		ph = {last_a, last_a ^ last_b};
		ph = up ? ph + 2'd1 : ph - 2'd1;
		push_sample(ph[1], ph[1] ^ ph[0], ix, st);
	endtask

	// an a edge on every item, all in one direction
	task automatic sweep_count(input logic up, input int n);
		logic a;
		for (int i = 0; i < n; i++) begin
			a = ~last_a;
			push_sample(a, up ? a : ~a, 1'b1, $urandom_range(7) == 0);
		end
	endtask

	task automatic pulse_index();
		push_sample(last_a, last_b, 1'b1, 1'b0);
		push_sample(last_a, last_b, 1'b0, 1'b1);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		// covers the longest frame latch
		repeat (12) @(negedge clk);
	endtask

	task automatic set_scale(input logic [SCALE_W-1:0] v);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scale_writes++;
	endtask

	task automatic random_walk(input int n);
		int   kind;
		logic ix, st;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			if (index_low > 0)
				index_low--;
			else if ($urandom_range(99) < 3)
				index_low = $urandom_range(3, 1);
			ix = (index_low == 0);
			st = 1'($urandom_range(1));
			if (kind < 75) begin
				if (run_left == 0) begin
					run_up   = 1'($urandom_range(1));
					run_left = $urandom_range(120, 1);
				end
				run_left--;
				quad_move(run_up, ix, st);
			end else if (kind < 90) begin
				push_sample(1'($urandom_range(1)), 1'($urandom_range(1)), ix, st);
			end else begin
				push_sample(last_a, last_b, ix, st);
			end
		end
	endtask

	initial begin
		logic [SCALE_W-1:0] v;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: counting both ways, b-only changes, negative frame with minus
		push_sample(1'b0, 1'b0, 1'b1, 1'b0);
		push_sample(1'b1, 1'b1, 1'b1, 1'b0);
		push_sample(1'b0, 1'b0, 1'b1, 1'b0);
		push_sample(1'b1, 1'b0, 1'b1, 1'b0);
		push_sample(1'b1, 1'b1, 1'b1, 1'b0);
		push_sample(1'b0, 1'b1, 1'b1, 1'b0);
		push_sample(1'b1, 1'b0, 1'b1, 1'b0);
		push_sample(1'b0, 1'b1, 1'b1, 1'b0);
		push_sample(1'b1, 1'b0, 1'b1, 1'b1);
		repeat (8) push_sample(1'b1, 1'b0, 1'b1, 1'b1);
		// index falling together with an a edge, then index held low and rising
		push_sample(1'b0, 1'b1, 1'b0, 1'b0);
		push_sample(1'b1, 1'b1, 1'b0, 1'b1);
		push_sample(1'b1, 1'b1, 1'b1, 1'b1);
		push_sample(1'b0, 1'b0, 1'b0, 1'b1);
		push_sample(1'b0, 1'b0, 1'b0, 1'b0);
		push_sample(1'b1, 1'b1, 1'b1, 1'b1);

		// sweep up and down, frames with several digits with and without minus
		sweep_count(1'b1, 40);
		pulse_index();
		sweep_count(1'b0, 40);
		pulse_index();

		for (int k = 0; k < 8; k++) begin
			case (k)
				0: v = 4'd1;
				1: v = 4'd0;
				2: v = 4'd15;
				3: v = 4'd10;
				4: v = 4'd5;
				5: v = 4'd9;
				6: v = 4'd2;
				default: v = SCALE_W'($urandom_range(9, 1));
			endcase
			set_scale(v);
			case (k % 4)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 55; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 55; end
				default: begin src_idle = 24; sink_stall = 24; end
			endcase
			random_walk(62);
		end

		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("%0d encoder items driven and %0d readouts checked over %0d scale writes",
			items_seen, readouts_seen, scale_writes);
		$display("count swept both ways, cleared by the index line, under all idling phases");
		if (mismatches == 0 && outstanding == 0)
			$display("[quadrature_angle_seven_segment_display_unit] OK");
		else
			$display("[quadrature_angle_seven_segment_display_unit] ERROR");
		$finish;
	end

endmodule
